/* rtl/tps_pkg.sv */
`default_nettype none

package tps_pkg;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [7:0] id;
        logic [3:0] prio;
        logic [6:0] rem;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_APPLY,
        S_SCAN2,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_RUN_HEAD = 2'd1,
        REQ_RUN_ID   = 2'd2,
        REQ_REMOVE   = 2'd3
    } t_req;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_NONE  = 3'd1;
    localparam logic [2:0] STAT_FULL  = 3'd2;
    localparam logic [2:0] STAT_BAD   = 3'd3;
    localparam logic [2:0] STAT_NO_ID = 3'd4;

    localparam logic       POL_PRIO   = 1'b0;
    localparam logic [3:0] PRIO_LIMIT = 4'd9;
    localparam logic [6:0] RUNS_LIMIT = 7'd100;
    localparam logic [7:0] FIRST_ID   = 8'd1;

endpackage

`default_nettype wire

/* rtl/tps_req_if.sv */
`default_nettype none

interface tps_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] task_id;
    logic [3:0] task_priority;
    logic [6:0] run_count;

    modport source (output valid, output req_type, output task_id,
                    output task_priority, output run_count, input ready);
    modport sink   (input valid, input req_type, input task_id,
                    input task_priority, input run_count, output ready);
endinterface

`default_nettype wire

/* rtl/tps_rsp_if.sv */
`default_nettype none

interface tps_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] assigned_id;
    logic       finished;
    logic [7:0] head_id;
    logic [3:0] head_priority;
    logic [6:0] head_remaining;
    logic [4:0] task_count;

    modport source (output valid, output status, output assigned_id, output finished,
                    output head_id, output head_priority, output head_remaining,
                    output task_count, input ready);
    modport sink   (input valid, input status, input assigned_id, input finished,
                    input head_id, input head_priority, input head_remaining,
                    input task_count, output ready);
endinterface

`default_nettype wire

/* rtl/tps_cfg_if.sv */
`default_nettype none

interface tps_cfg_if;
    logic valid;
    logic ready;
    logic policy;

    modport source (output valid, output policy, input ready);
    modport sink   (input valid, input policy, output ready);
endinterface

`default_nettype wire

/* rtl/tps_cmp.sv */
`default_nettype none

module tps_cmp
    import tps_pkg::*;
(
    input  logic   i_policy,
    input  t_entry i_cand,
    input  t_entry i_best,
    output logic   o_ahead
);

    // True when the candidate entry should come before the current best.
    // Ties on the policy key go to the larger, newer id.
    always_comb begin
        if (i_policy == POL_PRIO && i_cand.prio != i_best.prio) begin
            o_ahead = (i_cand.prio > i_best.prio);
        end else if (i_policy != POL_PRIO && i_cand.rem != i_best.rem) begin
            o_ahead = (i_cand.rem < i_best.rem);
        end else begin
            o_ahead = (i_cand.id > i_best.id);
        end
    end

endmodule

`default_nettype wire

/* rtl/task_priority_scheduler.sv */
// A request is taken only in idle and then runs two table scans, one before and one after
// its update; each of the two table scans reads one entry per cycle. The shared compare
// unit and the single read port of the entry memory make the scans run one after the other.
// Requests are not taken meanwhile, nor while a finished result waits for the output
// register to be freed.
// Reset (synchronous, active low): table empty, policy 0, next id 1, no result pending.
`default_nettype none

module task_priority_scheduler
    import tps_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tps_req_if.sink    i_req,
    tps_rsp_if.source  o_rsp,
    tps_cfg_if.sink    i_cfg
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

    // Control and policy state.
    t_state          r_state, n_state;
    logic            r_policy;
    logic [MAX_TASKS-1:0] r_valid;
    logic [CW-1:0]   r_count;
    logic [7:0]      r_next_id;

    // Entry memory and its registered read port.
    t_entry          r_mem [MAX_TASKS];
    logic [IW-1:0]   r_addr;
    logic            r_iss;
    logic            r_rd_vld;
    logic [IW-1:0]   r_rd_idx;
    t_entry          r_rd_data;

    // The request being worked on.
    logic [1:0]      r_req_type;
    logic [7:0]      r_tid;
    logic [3:0]      r_prio;
    logic [6:0]      r_runs;

    // Scan accumulators.
    logic            r_hfound;
    t_entry          r_best;
    logic [IW-1:0]   r_best_idx;
    logic            r_found;
    t_entry          r_match_ent;
    logic [IW-1:0]   r_match_idx;
    logic            r_free_found;
    logic [IW-1:0]   r_free_idx;

    // Per-request result fields, settled in the apply step.
    logic [2:0]      r_status;
    logic [7:0]      r_assigned;
    logic            r_finished;

    // Output register.
    logic            r_out_valid;
    logic [2:0]      r_out_status;
    logic [7:0]      r_out_assigned;
    logic            r_out_finished;
    logic [7:0]      r_out_head_id;
    logic [3:0]      r_out_head_prio;
    logic [6:0]      r_out_head_rem;
    logic [4:0]      r_out_count;

    // Sequencer controls.
    logic            c_accept;
    logic            c_start;
    logic            c_last;
    logic            c_load_out;

    logic            cur_v;
    logic            cur_ahead;

    // Apply decode.
    logic [2:0]      a_status;
    logic [7:0]      a_assigned;
    logic            a_finished;
    logic            a_wr;
    logic [IW-1:0]   a_idx;
    t_entry          a_data;
    logic            a_set;
    logic            a_clr;
    logic            tgt_ok;
    logic [IW-1:0]   tgt_idx;
    t_entry          tgt_ent;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign c_accept    = i_req.valid && (r_state == S_IDLE);
    assign c_last      = r_rd_vld && (r_rd_idx == LAST_IDX);
    assign cur_v       = r_valid[r_rd_idx];

    // The one compare unit, shared by both scans.
    tps_cmp u_cmp (
        .i_policy (r_policy),
        .i_cand   (r_rd_data),
        .i_best   (r_best),
        .o_ahead  (cur_ahead)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_SCAN1;
            end
            S_SCAN1: begin
                if (c_last) n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = S_SCAN2;
            end
            S_SCAN2: begin
                if (c_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        c_start    = 1'b0;
        c_load_out = 1'b0;
        unique case (r_state)
            S_IDLE:   c_start    = i_req.valid;
            S_APPLY:  c_start    = 1'b1;
            S_FINISH: c_load_out = !r_out_valid || o_rsp.ready;
            default: begin
                c_start    = 1'b0;
                c_load_out = 1'b0;
            end
        endcase
    end

    // Decide what the request does to the table, from the first scan's findings.
    always_comb begin
        a_status   = STAT_OK;
        a_assigned = 8'd0;
        a_finished = 1'b0;
        a_wr       = 1'b0;
        a_idx      = r_free_idx;
        a_data     = '{id: r_next_id, prio: r_prio, rem: r_runs};
        a_set      = 1'b0;
        a_clr      = 1'b0;
        tgt_ok     = (r_req_type == REQ_RUN_HEAD) ? r_hfound    : r_found;
        tgt_idx    = (r_req_type == REQ_RUN_HEAD) ? r_best_idx  : r_match_idx;
        tgt_ent    = (r_req_type == REQ_RUN_HEAD) ? r_best      : r_match_ent;
        unique case (r_req_type)
            REQ_ADD: begin
                if (r_prio < 4'd1 || r_prio >= PRIO_LIMIT ||
                    r_runs < 7'd1 || r_runs >= RUNS_LIMIT) begin
                    a_status = STAT_BAD;
                end else if (!r_free_found) begin
                    a_status = STAT_FULL;
                end else if (r_next_id == 8'd0) begin
                    a_status = STAT_NO_ID;
                end else begin
                    a_wr       = 1'b1;
                    a_set      = 1'b1;
                    a_assigned = r_next_id;
                end
            end
            REQ_RUN_HEAD, REQ_RUN_ID: begin
                a_idx = tgt_idx;
                if (!tgt_ok) begin
                    a_status = STAT_NONE;
                end else if (tgt_ent.rem > 7'd1) begin
                    a_wr       = 1'b1;
                    a_data     = tgt_ent;
                    a_data.rem = tgt_ent.rem - 7'd1;
                end else begin
                    a_clr      = 1'b1;
                    a_finished = 1'b1;
                end
            end
            REQ_REMOVE: begin
                a_idx = tgt_idx;
                if (!tgt_ok) begin
                    a_status = STAT_NONE;
                end else begin
                    a_clr = 1'b1;
                end
            end
            default: a_status = STAT_NONE;
        endcase
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY && a_wr) begin
            r_mem[a_idx] <= a_data;
        end
        if (r_iss) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_next_id   <= FIRST_ID;
            r_iss       <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_policy <= i_cfg.policy;
            end

            // Read address sequencing for a scan over all slots.
            if (c_start) begin
                r_iss <= 1'b1;
            end else if (r_iss && r_addr == LAST_IDX) begin
                r_iss <= 1'b0;
            end
            r_rd_vld <= r_iss;

            if (r_state == S_APPLY) begin
                if (a_set) begin
                    r_valid[a_idx] <= 1'b1;
                    r_count        <= r_count + CW'(1);
                    r_next_id      <= r_next_id + 8'd1;
                end else if (a_clr) begin
                    r_valid[a_idx] <= 1'b0;
                    r_count        <= r_count - CW'(1);
                end
            end

            if (c_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: request capture, scan accumulators, result fields.
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_req_type <= i_req.req_type;
            r_tid      <= i_req.task_id;
            r_prio     <= i_req.task_priority;
            r_runs     <= i_req.run_count;
        end

        if (c_start) begin
            r_addr <= '0;
        end else if (r_iss && r_addr != LAST_IDX) begin
            r_addr <= r_addr + IW'(1);
        end
        r_rd_idx <= r_addr;

        if (c_start) begin
            r_hfound     <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_rd_vld) begin
            // Head search runs in both scans.
            if (cur_v && (!r_hfound || cur_ahead)) begin
                r_hfound   <= 1'b1;
                r_best     <= r_rd_data;
                r_best_idx <= r_rd_idx;
            end
            // Id lookup and lowest free slot only matter before the update.
            if (r_state == S_SCAN1) begin
                if (cur_v && !r_found && r_tid != 8'd0 && r_rd_data.id == r_tid) begin
                    r_found     <= 1'b1;
                    r_match_ent <= r_rd_data;
                    r_match_idx <= r_rd_idx;
                end
                if (!cur_v && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_rd_idx;
                end
            end
        end

        if (r_state == S_APPLY) begin
            r_status   <= a_status;
            r_assigned <= a_assigned;
            r_finished <= a_finished;
        end

        if (c_load_out) begin
            r_out_status    <= r_status;
            r_out_assigned  <= r_assigned;
            r_out_finished  <= r_finished;
            r_out_head_id   <= r_hfound ? r_best.id   : 8'd0;
            r_out_head_prio <= r_hfound ? r_best.prio : 4'd0;
            r_out_head_rem  <= r_hfound ? r_best.rem  : 7'd0;
            r_out_count     <= 5'(r_count);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.assigned_id    = r_out_assigned;
    assign o_rsp.finished       = r_out_finished;
    assign o_rsp.head_id        = r_out_head_id;
    assign o_rsp.head_priority  = r_out_head_prio;
    assign o_rsp.head_remaining = r_out_head_rem;
    assign o_rsp.task_count     = r_out_count;

    // The task count register tracks the valid bits exactly.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("task count out of step with valid bits");

    // The count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count above table size");

    // An accepted request starts a clean first scan.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_SCAN1 && !r_hfound && !r_rd_vld))
        else $error("first scan did not start cleanly");

    // Once ids are exhausted they stay exhausted.
    a_ids_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_id == 8'd0) |=> (r_next_id == 8'd0))
        else $error("id supply revived after exhaustion");

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tps_pkg::*;

    // Table depth of the scheduler under test. It is kept at the default so that
    // the table can be filled up within a handful of requests.
    localparam int TBL_DEPTH = 16;
    // Policy value that orders by fewest remaining runs; POL_PRIO is the other one.
    localparam logic POL_FEWEST = 1'b1;
    // Length of the one long stall on the result side, in cycles.
    localparam int LONG_HOLD = 300;
    // Random requests after the directed part, split over phases with their own policy.
    localparam int RANDOM_ITEMS = 1975;
    localparam int PHASES = 6;
    // Requests near the end of the run that go through with no idling at all.
    localparam int TAIL_ITEMS = 250;
    localparam int MAX_PRINTS = 50;

    // One item for the request side, or a write of the policy register.
    typedef struct packed {
        logic       is_policy;
        logic       policy;
        t_req       kind;
        logic [7:0] tid;
        logic [3:0] prio;
        logic [6:0] runs;
    } t_stim;

    // One result item as the scheduler should report it.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] assigned_id;
        logic       finished;
        logic [7:0] head_id;
        logic [3:0] head_priority;
        logic [6:0] head_remaining;
        logic [4:0] task_count;
    } t_outcome;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tps_req_if req_bus ();
    tps_rsp_if rsp_bus ();
    tps_cfg_if cfg_bus ();

    task_priority_scheduler #(
        .MAX_TASKS(TBL_DEPTH)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus),
        .i_cfg  (cfg_bus)
    );

    // The clock runs with a 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset is held low at the start and never asserted again.
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Every input of the scheduler is known from time zero.
    initial begin
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_ADD;
        req_bus.task_id       = '0;
        req_bus.task_priority = '0;
        req_bus.run_count     = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.policy        = POL_PRIO;
        rsp_bus.ready         = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the task table. It is updated when a request is accepted
    // and yields the result that this request must produce.
    // ------------------------------------------------------------------
    logic       tbl_valid [TBL_DEPTH];
    logic [7:0] tbl_id    [TBL_DEPTH];
    logic [3:0] tbl_prio  [TBL_DEPTH];
    logic [6:0] tbl_rem   [TBL_DEPTH];
    logic [7:0] next_task_id = FIRST_ID;
    logic       sched_policy = POL_PRIO;

    initial begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_id[i]    = '0;
            tbl_prio[i]  = '0;
            tbl_rem[i]   = '0;
        end
    end

    // Results still owed by the scheduler, oldest first.
    t_outcome rsp_due[$];
    // Requests and register writes waiting for the driver.
    t_stim    req_backlog[$];

    int mismatches = 0;

    // True when slot a is to be served before slot b under the current policy.
    // Equal keys fall to the newer task, which has the larger id.
    function automatic bit goes_first(input int a, input int b);
        if (sched_policy == POL_PRIO) begin
            if (tbl_prio[a] != tbl_prio[b]) begin
                return tbl_prio[a] > tbl_prio[b];
            end
        end else begin
            if (tbl_rem[a] != tbl_rem[b]) begin
                return tbl_rem[a] < tbl_rem[b];
            end
        end
        return tbl_id[a] > tbl_id[b];
    endfunction

    function automatic int head_slot();
        int best;
        best = -1;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (tbl_valid[i] && (best < 0 || goes_first(i, best))) begin
                best = i;
            end
        end
        return best;
    endfunction

    // One pass of the task in slot s; the task leaves the table on its last run.
    function automatic logic run_once(input int s);
        if (tbl_rem[s] > 7'd1) begin
            tbl_rem[s] = tbl_rem[s] - 7'd1;
            return 1'b0;
        end
        tbl_valid[s] = 1'b0;
        return 1'b1;
    endfunction

    // Applies one accepted request to the shadow table and queues its result.
    function automatic void apply_request(input t_stim r);
        t_outcome o;
        int       slot;
        int       h;
        int       held;
        o    = '0;
        slot = -1;
        case (r.kind)
            REQ_ADD: begin
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (!tbl_valid[i] && slot < 0) begin
                        slot = i;
                    end
                end
                // Bad values win over a full table, and a full table over the id supply.
                if (r.prio < 4'd1 || r.prio >= PRIO_LIMIT ||
                    r.runs < 7'd1 || r.runs >= RUNS_LIMIT) begin
                    o.status = STAT_BAD;
                end else if (slot < 0) begin
                    o.status = STAT_FULL;
                end else if (next_task_id == 8'd0) begin
                    o.status = STAT_NO_ID;
                end else begin
                    tbl_valid[slot] = 1'b1;
                    tbl_id[slot]    = next_task_id;
                    tbl_prio[slot]  = r.prio;
                    tbl_rem[slot]   = r.runs;
                    o.assigned_id   = next_task_id;
                    // After id 255 the counter wraps to 0 and the supply is gone.
                    next_task_id    = next_task_id + 8'd1;
                end
            end
            REQ_RUN_HEAD: begin
                slot = head_slot();
                if (slot < 0) begin
                    o.status = STAT_NONE;
                end else begin
                    o.finished = run_once(slot);
                end
            end
            default: begin
                // Id 0 is never given out, so it is never found.
                if (r.tid != 8'd0) begin
                    for (int i = 0; i < TBL_DEPTH; i++) begin
                        if (tbl_valid[i] && tbl_id[i] == r.tid && slot < 0) begin
                            slot = i;
                        end
                    end
                end
                if (slot < 0) begin
                    o.status = STAT_NONE;
                end else if (r.kind == REQ_RUN_ID) begin
                    o.finished = run_once(slot);
                end else begin
                    tbl_valid[slot] = 1'b0;
                end
            end
        endcase
        held = 0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (tbl_valid[i]) begin
                held++;
            end
        end
        o.task_count = 5'(held);
        h = head_slot();
        if (h >= 0) begin
            o.head_id        = tbl_id[h];
            o.head_priority  = tbl_prio[h];
            o.head_remaining = tbl_rem[h];
        end
        rsp_due.push_back(o);
    endfunction

    // ------------------------------------------------------------------
    // Idling. Both sides draw their gaps here: bursts of idle cycles of
    // random length, now and then a long stretch without any, and none at
    // all once the tail of the run has started.
    // ------------------------------------------------------------------
    logic no_idle_tail = 1'b0;

    function automatic int idle_burst(inout int quiet_left);
        if (no_idle_tail) begin
            return 0;
        end
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        case ($urandom_range(0, 7))
            0, 1: return $urandom_range(1, 11);
            2: begin
                quiet_left = $urandom_range(20, 80);
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver. It presents items from the backlog on the request channel
    // and register writes on the configuration channel. A register write
    // waits until every request sent so far has delivered its result, so
    // the scheduler is idle when the policy changes.
    // ------------------------------------------------------------------
    t_stim req_now;
    logic  cfg_now;
    int    reqs_open;
    int    send_gap;
    int    send_quiet = 0;
    int    send_idle;

    always @(posedge clk) begin
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
            cfg_bus.valid <= 1'b0;
            reqs_open = 0;
            send_gap  = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                reqs_open--;
            end
            if (req_bus.valid && req_bus.ready) begin
                apply_request(req_now);
                reqs_open++;
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                sched_policy = cfg_now;
            end

            if ((req_bus.valid && !req_bus.ready) || (cfg_bus.valid && !cfg_bus.ready)) begin
                // The item on offer has not been taken yet; keep it stable.
            end else if (send_gap > 0) begin
                send_gap--;
                req_bus.valid <= 1'b0;
                cfg_bus.valid <= 1'b0;
            end else if (req_backlog.size() == 0) begin
                req_bus.valid <= 1'b0;
                cfg_bus.valid <= 1'b0;
            end else if (req_backlog[0].is_policy) begin
                req_bus.valid <= 1'b0;
                if (reqs_open == 0) begin
                    cfg_now = req_backlog[0].policy;
                    void'(req_backlog.pop_front());
                    cfg_bus.policy <= cfg_now;
                    cfg_bus.valid  <= 1'b1;
                end else begin
                    cfg_bus.valid <= 1'b0;
                end
            end else begin
                cfg_bus.valid <= 1'b0;
                send_idle = idle_burst(send_quiet);
                if (send_idle > 0) begin
                    send_gap = send_idle - 1;
                    req_bus.valid <= 1'b0;
                end else begin
                    req_now = req_backlog.pop_front();
                    req_bus.req_type      <= req_now.kind;
                    req_bus.task_id       <= req_now.tid;
                    req_bus.task_priority <= req_now.prio;
                    req_bus.run_count     <= req_now.runs;
                    req_bus.valid         <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off. Once asked for, the result side stays not ready while
    // the LONG_HOLD countdown runs and the driver keeps offering requests, so the
    // scheduler must hold its result and stall the request channel.
    // ------------------------------------------------------------------
    logic hold_wanted = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left;

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_wanted && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each accepted result is compared field by field with the
    // oldest result still owed.
    // ------------------------------------------------------------------
    int take_gap;
    int take_quiet = 0;
    int take_idle;
    t_outcome want;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string field, input int got, input int exp_val);
        if (got != exp_val) begin
            report_mismatch($sformatf("%s is %0d, %0d was due", field, got, exp_val));
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch("result arrived with nothing owed");
                end else begin
                    want = rsp_due.pop_front();
                    check_field("status", rsp_bus.status, want.status);
                    check_field("assigned_id", rsp_bus.assigned_id, want.assigned_id);
                    check_field("finished", rsp_bus.finished, want.finished);
                    check_field("head_id", rsp_bus.head_id, want.head_id);
                    check_field("head_priority", rsp_bus.head_priority, want.head_priority);
                    check_field("head_remaining", rsp_bus.head_remaining,
                                want.head_remaining);
                    check_field("task_count", rsp_bus.task_count, want.task_count);
                end
            end

            if (hold_left > 0) begin
                rsp_bus.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                rsp_bus.ready <= 1'b0;
            end else begin
                take_idle = idle_burst(take_quiet);
                if (take_idle > 0) begin
                    take_gap = take_idle - 1;
                    rsp_bus.ready <= 1'b0;
                end else begin
                    rsp_bus.ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic push_req(input t_req kind, input int tid, input int prio, input int runs);
        t_stim s;
        s           = '0;
        s.kind      = kind;
        s.tid       = 8'(tid);
        s.prio      = 4'(prio);
        s.runs      = 7'(runs);
        req_backlog.push_back(s);
    endtask

    task automatic push_policy(input logic value);
        t_stim s;
        s           = '0;
        s.is_policy = 1'b1;
        s.policy    = value;
        req_backlog.push_back(s);
    endtask

    initial begin : stimulus
        t_stim      s;
        logic [7:0] held_ids[$];
        int         per_phase;
        int         pick;
        int         bad_mask;

        // The policy is written even though reset already cleared it.
        push_policy(POL_PRIO);

        // Requests on an empty table: nothing to run and no id to find, including id 0.
        push_req(REQ_RUN_HEAD, 0, 0, 0);
        push_req(REQ_RUN_ID, 0, 5, 5);
        push_req(REQ_REMOVE, 255, 15, 127);

        // Adds with a priority or a run count outside the legal range use no id.
        push_req(REQ_ADD, 0, 0, 5);
        push_req(REQ_ADD, 0, 9, 5);
        push_req(REQ_ADD, 255, 15, 127);
        push_req(REQ_ADD, 0, 3, 0);
        push_req(REQ_ADD, 0, 3, 100);

        // Sixteen good adds fill the table. Priorities repeat, so the id breaks
        // ties, and the run counts take both ends of their range.
        for (int k = 0; k < TBL_DEPTH; k++) begin
            push_req(REQ_ADD, k * 17, (k % 8) + 1,
                     (k == 0) ? 1 : (k == 1) ? 99 : ((k * 13) % 99) + 1);
        end
        // A good add on a full table.
        push_req(REQ_ADD, 0, 8, 99);

        // The random part runs in phases that alternate the policy. Most requests
        // act on tasks that are actually held; the rest are adds, good and malformed,
        // and runs or removes of arbitrary ids. Fields that a request does not use
        // carry random values. Short run counts dominate so that tasks finish
        // and the id supply is used up before the run ends.
        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            push_policy((p % 2 == 0) ? POL_FEWEST : POL_PRIO);
            for (int n = 0; n < per_phase; n++) begin
                while (req_backlog.size() >= 2) @(negedge clk);
                if (p == 1 && n == 20) begin
                    hold_wanted = 1'b1;
                end
                if (p == PHASES - 1 && n == per_phase - TAIL_ITEMS) begin
                    no_idle_tail = 1'b1;
                end

                held_ids.delete();
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (tbl_valid[i]) begin
                        held_ids.push_back(tbl_id[i]);
                    end
                end

                s      = '0;
                s.tid  = 8'($urandom_range(0, 255));
                s.prio = 4'($urandom_range(0, 15));
                s.runs = 7'($urandom_range(0, 127));
                pick   = $urandom_range(0, 99);
                if (pick < 15) begin
                    s.kind = REQ_ADD;
                    s.prio = 4'($urandom_range(1, 8));
                    case ($urandom_range(0, 9))
                        0:       s.runs = 7'($urandom_range(13, 99));
                        1, 2, 3: s.runs = 7'($urandom_range(5, 12));
                        default: s.runs = 7'($urandom_range(1, 4));
                    endcase
                end else if (pick < 18) begin
                    s.kind   = REQ_ADD;
                    bad_mask = $urandom_range(1, 3);
                    if (bad_mask[0]) begin
                        s.prio = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
                    end
                    if (bad_mask[1]) begin
                        s.runs = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(100, 127));
                    end
                end else if (pick < 53) begin
                    s.kind = REQ_RUN_HEAD;
                end else if (pick < 90) begin
                    s.kind = (pick < 83) ? REQ_RUN_ID : REQ_REMOVE;
                    if (held_ids.size() > 0) begin
                        s.tid = held_ids[$urandom_range(0, held_ids.size() - 1)];
                    end
                end else begin
                    s.kind = ($urandom_range(0, 1) == 0) ? REQ_RUN_ID : REQ_REMOVE;
                end
                req_backlog.push_back(s);
            end
        end

        // Drain: every request sent and every owed result checked, then a wait set
        // from the table depth so that a stray extra result would be caught.
        while (req_backlog.size() != 0 || req_bus.valid || cfg_bus.valid ||
               rsp_due.size() != 0) @(negedge clk);
        repeat (2 * (2 * TBL_DEPTH + 4)) @(negedge clk);
        if (mismatches == 0) begin
            $display("PASS task_priority_scheduler");
        end else begin
            $display("FAIL task_priority_scheduler");
        end
        $finish;
    end

    // The slowest correct run is about 2000 requests plus the long hold-off;
    // this limit is several times that.
    initial begin
        #6000000;
        $display("FAIL task_priority_scheduler");
        $finish;
    end

endmodule

/* files.f */
rtl/tps_pkg.sv
rtl/tps_req_if.sv
rtl/tps_rsp_if.sv
rtl/tps_cfg_if.sv
rtl/tps_cmp.sv
rtl/task_priority_scheduler.sv
verif/tb.sv
